@@ design/ste_pkg.sv @@
// Shared types and constants of the spark tachometer with averaged rpm.
package ste_pkg;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CHECK,
        ST_LOWMUL,
        ST_LOWCMP,
        ST_DIV,
        ST_EMAMUL,
        ST_DONE
    } state_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL  = 3'd5;

    // Register widths.
    localparam int HOLDOFF_W = 20;
    localparam int TIMEOUT_W = 24;
    localparam int CONFIRM_W = 4;
    localparam int FRAC_W    = 8;
    localparam int ALPHA_W   = 9;
    localparam int RPM_W     = 16;

    // Register reset values.
    localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST  = 20'd3750;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 24'd300000;
    localparam logic [CONFIRM_W-1:0] CONFIRM_RST  = 4'd5;
    localparam logic [FRAC_W-1:0]    FRAC_RST     = 8'd51;
    localparam logic [ALPHA_W-1:0]   ALPHA_RST    = 9'd77;
    localparam logic [RPM_W-1:0]     CRITICAL_RST = 16'd6000;

    // Unity weight of the average in Q8.
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    // Low-sample counter ceiling.
    localparam logic [CONFIRM_W-1:0] CNT_MAX = 4'd15;

    // Largest reportable rpm.
    localparam logic [RPM_W-1:0] RPM_MAX = 16'hFFFF;

    // Microseconds per minute, the dividend of the rpm division.
    localparam int QUO_W = 26;
    localparam logic [QUO_W-1:0] RPM_SCALE = 26'd60000000;

    // Reset value of the tracked minimum before masking to the sample width.
    localparam int MIN_RST = 1023;

endpackage

@@ design/ste_mul.sv @@
// Bit-serial signed by unsigned multiplier, one multiplier bit per cycle.
module ste_mul #(
    parameter int MCAND_W = 17
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      start,
    input  logic signed [MCAND_W-1:0]                 mcand,
    input  logic        [ste_pkg::ALPHA_W-1:0]        mplier,
    output logic                                      done,
    output logic signed [MCAND_W+ste_pkg::ALPHA_W-1:0] prod
);
    import ste_pkg::*;

    localparam int PW    = MCAND_W + ALPHA_W;
    localparam int CNT_W = $clog2(ALPHA_W + 1);

    logic                busy_reg,   busy_next;
    logic                done_reg,   done_next;
    logic [CNT_W-1:0]    cnt_reg,    cnt_next;
    logic signed [PW-1:0] mcand_reg, mcand_next;
    logic [ALPHA_W-1:0]  mplier_reg, mplier_next;
    logic signed [PW-1:0] acc_reg,   acc_next;

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (start) begin
            busy_next   = 1'b1;
            cnt_next    = CNT_W'(ALPHA_W);
            mcand_next  = PW'(mcand);
            mplier_next = mplier;
            acc_next    = '0;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

@@ design/ste_div.sv @@
// Restoring divider of the constant minute in microseconds by a period, one quotient bit per cycle.
module ste_div #(
    parameter int DIVISOR_W = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [DIVISOR_W-1:0]        divisor,
    output logic                        done,
    output logic [ste_pkg::QUO_W-1:0]   quotient
);
    import ste_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg,  cnt_next;
    logic [DIVISOR_W-1:0] div_reg,  div_next;
    logic [DIVISOR_W-1:0] rem_reg,  rem_next;
    logic [QUO_W-1:0]     quo_reg,  quo_next;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[QUO_W-1]};
        diff      = trial - {1'b0, div_reg};
        fits      = trial >= {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUO_W);
            div_next  = divisor;
            rem_next  = '0;
            quo_next  = RPM_SCALE;
        end else if (busy_reg) begin
            // A zero divisor always fits, so the quotient comes out all ones.
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ design/spark_tachometer_ema_core.sv @@
// Top level of the ignition-pulse tachometer with an exponentially averaged rpm.
// Each input beat yields one result beat. A sample with detection off passes EVAL and
// CHECK only; a tested sample also runs a 9-step serial multiply, and a confirmed spark
// adds the 26-step serial divider and a second 9-step serial multiply.
// The block takes one sample at a time; the output register lets the next sample in.
// Reset (aresetn, synchronous, active low) restores the registers and tracked state.
module spark_tachometer_ema_core #(
    parameter int SAMPLE_BITS = 10,
    parameter int TIME_BITS   = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ste_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ste_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [SAMPLE_BITS-1:0]            s_sample,
    input  logic [TIME_BITS-1:0]              s_timestamp_us,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ste_pkg::RPM_W-1:0]         m_rpm_average,
    output logic                              m_spark_seen,
    output logic                              m_range_ready,
    output logic                              m_over_critical
);
    import ste_pkg::*;

    // The multiplier serves both the threshold product (span by fraction) and the
    // average update (signed rpm difference by weight), so it is as wide as the larger.
    localparam int MUL_W = (SAMPLE_BITS + 1 > RPM_W + 1) ? SAMPLE_BITS + 1 : RPM_W + 1;
    localparam int PROD_W = MUL_W + ALPHA_W;
    // Width of the low test: sample*256 + frac*span stays below 2^(SAMPLE_BITS+9).
    localparam int LOW_W = SAMPLE_BITS + FRAC_W + 1;
    localparam logic [SAMPLE_BITS-1:0] LVL_MIN_RST = SAMPLE_BITS'(MIN_RST);

    // Configuration registers.
    logic [HOLDOFF_W-1:0] holdoff_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [CONFIRM_W-1:0] confirm_reg;
    logic [FRAC_W-1:0]    frac_reg;
    logic [ALPHA_W-1:0]   alpha_reg;
    logic [RPM_W-1:0]     critical_reg;

    // Sequencer and tracked state.
    state_t                 state_reg,      state_next;
    logic [SAMPLE_BITS-1:0] lvl_max_reg,    lvl_max_next;
    logic [SAMPLE_BITS-1:0] lvl_min_reg,    lvl_min_next;
    logic [CONFIRM_W-1:0]   low_cnt_reg,    low_cnt_next;
    logic [TIME_BITS-1:0]   last_spark_reg, last_spark_next;
    logic [RPM_W-1:0]       avg_reg,        avg_next;
    logic                   m_valid_reg,    m_valid_next;

    // Per-sample working registers.
    logic [SAMPLE_BITS-1:0] smp_reg,     smp_next;
    logic [TIME_BITS-1:0]   ts_reg,      ts_next;
    logic                   ready_reg,   ready_next;
    logic [TIME_BITS-1:0]   elapsed_reg, elapsed_next;
    logic [SAMPLE_BITS-1:0] span_reg,    span_next;
    logic                   spark_reg,   spark_next;

    // Output payload registers.
    logic [RPM_W-1:0] m_rpm_average_reg,   m_rpm_average_next;
    logic             m_spark_seen_reg,    m_spark_seen_next;
    logic             m_range_ready_reg,   m_range_ready_next;
    logic             m_over_critical_reg, m_over_critical_next;

    // Serial unit connections.
    logic                     mul_start;
    logic signed [MUL_W-1:0]  mul_mcand;
    logic [ALPHA_W-1:0]       mul_mplier;
    logic                     mul_done;
    logic signed [PROD_W-1:0] mul_prod;
    logic                     div_start;
    logic                     div_done;
    logic [QUO_W-1:0]         div_quo;

    // Intermediate combinational values.
    logic [LOW_W-1:0]         low_lhs;
    logic [LOW_W-1:0]         low_rhs;
    logic                     is_low;
    logic [CONFIRM_W-1:0]     cnt_upd;
    logic [RPM_W-1:0]         rpm_sat;
    logic signed [RPM_W:0]    rpm_diff;
    logic [ALPHA_W-1:0]       alpha_sat;
    logic signed [PROD_W-1:0] avg_sum;

    ste_mul #(
        .MCAND_W (MUL_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    ste_div #(
        .DIVISOR_W (TIME_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (elapsed_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Configuration is always accepted and lands at once; the host must write only
    // while no sample is in flight, which the block itself does not enforce.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            holdoff_reg  <= HOLDOFF_RST;
            timeout_reg  <= TIMEOUT_RST;
            confirm_reg  <= CONFIRM_RST;
            frac_reg     <= FRAC_RST;
            alpha_reg    <= ALPHA_RST;
            critical_reg <= CRITICAL_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_HOLDOFF:   holdoff_reg  <= cfg_data[HOLDOFF_W-1:0];
                REG_TIMEOUT:   timeout_reg  <= cfg_data[TIMEOUT_W-1:0];
                REG_CONFIRM:   confirm_reg  <= cfg_data[CONFIRM_W-1:0];
                REG_THRESHOLD: frac_reg     <= cfg_data[FRAC_W-1:0];
                REG_ALPHA:     alpha_reg    <= cfg_data[ALPHA_W-1:0];
                REG_CRITICAL:  critical_reg <= cfg_data[RPM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The block takes one sample at a time; it is open only between samples.
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        // A sample is low when it lies below max minus the fraction of the span,
        // compared in Q8 so that no precision is lost.
        low_lhs = LOW_W'({smp_reg, 8'h00}) + mul_prod[LOW_W-1:0];
        low_rhs = LOW_W'({lvl_max_reg, 8'h00});
        is_low  = low_lhs < low_rhs;

        if (is_low) begin
            cnt_upd = (low_cnt_reg == CNT_MAX) ? CNT_MAX : low_cnt_reg + 1'b1;
        end else begin
            cnt_upd = (low_cnt_reg == '0) ? '0 : low_cnt_reg - 1'b1;
        end

        // Any quotient bit above the rpm width means the period was too short to report.
        rpm_sat   = (|div_quo[QUO_W-1:RPM_W]) ? RPM_MAX : div_quo[RPM_W-1:0];
        rpm_diff  = $signed({1'b0, rpm_sat}) - $signed({1'b0, avg_reg});
        alpha_sat = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;

        // (a*rpm + (256-a)*avg) >> 8 equals avg + floor(a*(rpm-avg) / 256).
        avg_sum = PROD_W'($signed({1'b0, avg_reg})) + (mul_prod >>> 8);

        state_next           = state_reg;
        lvl_max_next         = lvl_max_reg;
        lvl_min_next         = lvl_min_reg;
        low_cnt_next         = low_cnt_reg;
        last_spark_next      = last_spark_reg;
        avg_next             = avg_reg;
        m_valid_next         = m_valid_reg;
        smp_next             = smp_reg;
        ts_next              = ts_reg;
        ready_next           = ready_reg;
        elapsed_next         = elapsed_reg;
        span_next            = span_reg;
        spark_next           = spark_reg;
        m_rpm_average_next   = m_rpm_average_reg;
        m_spark_seen_next    = m_spark_seen_reg;
        m_range_ready_next   = m_range_ready_reg;
        m_over_critical_next = m_over_critical_reg;
        mul_start            = 1'b0;
        mul_mcand            = MUL_W'($signed({1'b0, span_reg}));
        mul_mplier           = ALPHA_W'(frac_reg);
        div_start            = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    smp_next   = s_sample;
                    ts_next    = s_timestamp_us;
                    spark_next = 1'b0;
                    if (s_sample > lvl_max_reg) begin
                        lvl_max_next = s_sample;
                    end
                    if (s_sample < lvl_min_reg) begin
                        lvl_min_next = s_sample;
                    end
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                ready_next   = lvl_max_reg > lvl_min_reg;
                elapsed_next = ts_reg - last_spark_reg;
                span_next    = lvl_max_reg - lvl_min_reg;
                state_next   = ST_CHECK;
            end
            ST_CHECK: begin
                // Detection and the timeout are both skipped until the range is known
                // and the hold-off since the last spark has passed.
                if (ready_reg && (elapsed_reg >= TIME_BITS'(holdoff_reg))) begin
                    mul_start  = 1'b1;
                    state_next = ST_LOWMUL;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_LOWMUL: begin
                if (mul_done) begin
                    state_next = ST_LOWCMP;
                end
            end
            ST_LOWCMP: begin
                if (cnt_upd >= confirm_reg) begin
                    spark_next      = 1'b1;
                    last_spark_next = ts_reg;
                    low_cnt_next    = '0;
                    div_start       = 1'b1;
                    state_next      = ST_DIV;
                end else begin
                    low_cnt_next = cnt_upd;
                    // After a spark the elapsed time is zero, so only this path times out.
                    if (elapsed_reg > TIME_BITS'(timeout_reg)) begin
                        avg_next = '0;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    mul_start  = 1'b1;
                    mul_mcand  = MUL_W'(rpm_diff);
                    mul_mplier = alpha_sat;
                    state_next = ST_EMAMUL;
                end
            end
            ST_EMAMUL: begin
                if (mul_done) begin
                    avg_next   = avg_sum[RPM_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hand the result to the output register as soon as it is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_rpm_average_next   = avg_reg;
                    m_spark_seen_next    = spark_reg;
                    m_range_ready_next   = ready_reg;
                    m_over_critical_next = avg_reg > critical_reg;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            lvl_max_reg    <= '0;
            lvl_min_reg    <= LVL_MIN_RST;
            low_cnt_reg    <= '0;
            last_spark_reg <= '0;
            avg_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            lvl_max_reg    <= lvl_max_next;
            lvl_min_reg    <= lvl_min_next;
            low_cnt_reg    <= low_cnt_next;
            last_spark_reg <= last_spark_next;
            avg_reg        <= avg_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        smp_reg             <= smp_next;
        ts_reg              <= ts_next;
        ready_reg           <= ready_next;
        elapsed_reg         <= elapsed_next;
        span_reg            <= span_next;
        spark_reg           <= spark_next;
        m_rpm_average_reg   <= m_rpm_average_next;
        m_spark_seen_reg    <= m_spark_seen_next;
        m_range_ready_reg   <= m_range_ready_next;
        m_over_critical_reg <= m_over_critical_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_rpm_average   = m_rpm_average_reg;
    assign m_spark_seen    = m_spark_seen_reg;
    assign m_range_ready   = m_range_ready_reg;
    assign m_over_critical = m_over_critical_reg;

`ifndef SYNTHESIS
    // A confirmed spark can only come from a sample tested against a known range.
    a_spark_needs_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_spark_seen) |-> m_range_ready)
        else $error("spark reported without a valid range");

    // The multiplier finishes only while the sequencer waits for it.
    a_mul_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_LOWMUL || state_reg == ST_EMAMUL))
        else $error("multiplier finished outside a multiply state");

    // The divider finishes only while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    // A confirmed spark restarts the low-sample count.
    a_spark_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOWCMP && div_start) |=> (low_cnt_reg == '0))
        else $error("low counter not cleared after a spark");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the spark tachometer with exponentially averaged rpm.
module testbench;
    import ste_pkg::*;

    localparam int SAMPLE_BITS  = 10;
    localparam int TIME_BITS    = 32;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 135;
    localparam int SETTLE_CYCLES = 60;

    // One ignition-voltage sample as it travels on the input channel.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] smp;
        logic [TIME_BITS-1:0]   ts;
    } ign_sample_t;

    // One tachometer reading as it travels on the result channel.
    typedef struct packed {
        logic [RPM_W-1:0] rpm_avg;
        logic             spark;
        logic             ready;
        logic             over;
    } tach_reading_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [SAMPLE_BITS-1:0] s_sample = '0;
    logic [TIME_BITS-1:0]   s_timestamp_us = '0;

    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [RPM_W-1:0]       m_rpm_average;
    logic                   m_spark_seen;
    logic                   m_range_ready;
    logic                   m_over_critical;

    spark_tachometer_ema_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_timestamp_us  (s_timestamp_us),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rpm_average   (m_rpm_average),
        .m_spark_seen    (m_spark_seen),
        .m_range_ready   (m_range_ready),
        .m_over_critical (m_over_critical)
    );

    // Samples waiting to be driven, and the readings the tachometer owes us, oldest first.
    ign_sample_t   sample_q[$];
    tach_reading_t reading_q[$];

    int mismatches    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int queued_count  = 0;

    // Running timestamp used when building synthetic ignition waveforms.
    logic [TIME_BITS-1:0] stim_clock = '0;

    // Our own copy of the configuration registers, starting from their reset values.
    logic [HOLDOFF_W-1:0] cfg_holdoff  = HOLDOFF_RST;
    logic [TIMEOUT_W-1:0] cfg_timeout  = TIMEOUT_RST;
    logic [CONFIRM_W-1:0] cfg_confirm  = CONFIRM_RST;
    logic [FRAC_W-1:0]    cfg_frac     = FRAC_RST;
    logic [ALPHA_W-1:0]   cfg_alpha    = ALPHA_RST;
    logic [RPM_W-1:0]     cfg_critical = CRITICAL_RST;

    // Our own copy of the tracking state.
    logic [SAMPLE_BITS-1:0] lvl_max    = '0;
    logic [SAMPLE_BITS-1:0] lvl_min    = SAMPLE_BITS'(MIN_RST);
    logic [CONFIRM_W-1:0]   low_count  = '0;
    logic [TIME_BITS-1:0]   last_spark = '0;
    logic [RPM_W-1:0]       avg_rpm    = '0;

    // The clock runs free with a 2 ns period.
    initial begin
        forever #1 aclk = ~aclk;
    end

    // Works out the reading that one accepted sample produces and advances the
    // tracking state. Every sample yields exactly one reading.
    function automatic tach_reading_t predict_reading(input logic [SAMPLE_BITS-1:0] smp,
                                                      input logic [TIME_BITS-1:0] ts);
        tach_reading_t   r;
        logic [TIME_BITS-1:0] elapsed;
        logic [63:0]     lhs;
        logic [63:0]     rhs;
        logic [63:0]     rpm;
        logic [63:0]     weight;
        r = '0;
        if (smp > lvl_max) lvl_max = smp;
        if (smp < lvl_min) lvl_min = smp;
        r.ready = (lvl_max > lvl_min);

        // Nothing is detected and no timeout is applied until the range opens up
        // and the hold-off since the last spark has run out.
        if (r.ready) begin
            elapsed = ts - last_spark;
            if (64'(elapsed) >= 64'(cfg_holdoff)) begin
                // The low test is done exactly, without dividing the span.
                lhs = 64'(smp) * 64'd256 + 64'(cfg_frac) * 64'(lvl_max - lvl_min);
                rhs = 64'(lvl_max) * 64'd256;
                if (lhs < rhs) begin
                    if (low_count < CNT_MAX) low_count = low_count + 1'b1;
                end else if (low_count != '0) begin
                    low_count = low_count - 1'b1;
                end

                // A confirm count of zero makes every sample past the hold-off a spark.
                if (low_count >= cfg_confirm) begin
                    r.spark    = 1'b1;
                    last_spark = ts;
                    low_count  = '0;
                    // A zero period can only happen with no hold-off; it reads as the top rpm.
                    if (elapsed == '0)
                        rpm = 64'(RPM_MAX);
                    else
                        rpm = 64'(RPM_SCALE) / 64'(elapsed);
                    if (rpm > 64'(RPM_MAX)) rpm = 64'(RPM_MAX);
                    // Weights above unity saturate; a zero weight holds the average.
                    weight  = (cfg_alpha > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(cfg_alpha);
                    avg_rpm = RPM_W'((weight * rpm
                              + (64'(ALPHA_ONE) - weight) * 64'(avg_rpm)) >> 8);
                end

                // The timeout is measured from the latest spark, possibly this one.
                if (64'(TIME_BITS'(ts - last_spark)) > 64'(cfg_timeout))
                    avg_rpm = '0;
            end
        end

        r.rpm_avg = avg_rpm;
        r.over    = (avg_rpm > cfg_critical);
        return r;
    endfunction

    // Sample driver. A new beat is offered only when the previous one has gone,
    // and the offered beat is held steady until the tachometer takes it.
    always @(posedge aclk) begin : sample_driver
        ign_sample_t nxt;
        logic        busy;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            busy = s_valid && !s_ready;
            if (s_valid && s_ready)
                reading_q.push_back(predict_reading(s_sample, s_timestamp_us));
            if (!busy) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = sample_q.pop_front();
                    s_valid        <= 1'b1;
                    s_sample       <= nxt.smp;
                    s_timestamp_us <= nxt.ts;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Reading monitor. Every accepted result beat is matched against the oldest
    // expected reading, field by field; the ready line stalls at random.
    always @(posedge aclk) begin : reading_monitor
        tach_reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (reading_q.size() == 0) begin
                $error("result beat arrived with no reading expected");
                mismatches++;
            end else begin
                want = reading_q.pop_front();
                if (m_rpm_average !== want.rpm_avg) begin
                    $error("rpm_average: expected %0d, got %0d", want.rpm_avg, m_rpm_average);
                    mismatches++;
                end
                if (m_spark_seen !== want.spark) begin
                    $error("spark_seen: expected %0d, got %0d", want.spark, m_spark_seen);
                    mismatches++;
                end
                if (m_range_ready !== want.ready) begin
                    $error("range_ready: expected %0d, got %0d", want.ready, m_range_ready);
                    mismatches++;
                end
                if (m_over_critical !== want.over) begin
                    $error("over_critical: expected %0d, got %0d", want.over, m_over_critical);
                    mismatches++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic push_sample(input int unsigned smp, input logic [TIME_BITS-1:0] ts);
        ign_sample_t item;
        item.smp = SAMPLE_BITS'(smp);
        item.ts  = ts;
        sample_q.push_back(item);
        queued_count++;
    endtask

    // Writes one register over the configuration channel and mirrors it into
    // our copy once the beat has been taken. Only called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_HOLDOFF:   cfg_holdoff  = data[HOLDOFF_W-1:0];
            REG_TIMEOUT:   cfg_timeout  = data[TIMEOUT_W-1:0];
            REG_CONFIRM:   cfg_confirm  = data[CONFIRM_W-1:0];
            REG_THRESHOLD: cfg_frac     = data[FRAC_W-1:0];
            REG_ALPHA:     cfg_alpha    = data[ALPHA_W-1:0];
            REG_CRITICAL:  cfg_critical = data[RPM_W-1:0];
            default: ;
        endcase
    endtask

    // Waits until every sample has been driven and every reading has come back.
    task automatic wait_drained();
        do @(posedge aclk);
        while (sample_q.size() != 0 || s_valid || reading_q.size() != 0);
    endtask

    // Queues one engine revolution: a burst of low samples that should confirm a
    // spark, followed by high samples spread over the rest of the period. Some
    // bursts are cut short so the counter has to decay again, and some periods
    // are stretched to run into the no-spark timeout.
    task automatic queue_revolution();
        int unsigned knee;
        int unsigned lo_cap;
        int unsigned hi_floor;
        int unsigned n_low;
        int unsigned n_high;
        int unsigned dt_low;
        int unsigned dt_high;
        int unsigned period;
        int unsigned smp;
        knee     = lvl_max * 256 - cfg_frac * (lvl_max - lvl_min);
        lo_cap   = (knee > 256) ? (knee - 1) / 256 : 0;
        hi_floor = (knee + 255) / 256;
        if (hi_floor > lvl_max) hi_floor = lvl_max;
        if (lo_cap < lvl_min) lo_cap = lvl_min;

        if ($urandom_range(7) == 0)
            n_low = $urandom_range(cfg_confirm, 0);
        else
            n_low = cfg_confirm + $urandom_range(2, 0);
        n_high = $urandom_range(6, 2);
        dt_low = $urandom_range(40, 0);
        period = cfg_holdoff + 800 + $urandom_range(60000, 0);
        if ($urandom_range(9) == 0)
            period += $urandom_range(cfg_timeout, 0);
        dt_high = (period - n_low * dt_low) / n_high;

        for (int i = 0; i < n_low; i++) begin
            smp = ($urandom_range(3) == 0) ? lo_cap : $urandom_range(lo_cap, lvl_min);
            push_sample(smp, stim_clock);
            stim_clock += dt_low;
        end
        for (int i = 0; i < n_high; i++) begin
            smp = ($urandom_range(3) == 0) ? hi_floor : $urandom_range(lvl_max, hi_floor);
            push_sample(smp, stim_clock);
            stim_clock += dt_high;
        end
    endtask

    // Queues unstructured samples: random levels, with timestamps that either
    // creep forward or jump anywhere in the 32-bit range.
    task automatic queue_noise(input int count);
        logic [TIME_BITS-1:0] ts;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(2) == 0) begin
                ts = $urandom;
            end else begin
                stim_clock += $urandom_range(5000, 0);
                ts = stim_clock;
            end
            push_sample($urandom_range(1023, 0), ts);
        end
    endtask

    // Programs all six registers for one phase. The first phases pin the
    // extremes; the last two pick everything at random.
    task automatic program_phase(input int ph);
        int unsigned holdoff, timeout, confirm, frac, alpha, critical;
        case (ph)
            0: begin
                holdoff = 3750; timeout = 300000; confirm = 5;
                frac = 51; alpha = 77; critical = 6000;
            end
            1: begin
                holdoff = 0; timeout = 24'hFFFFFF; confirm = 1;
                frac = 0; alpha = 256; critical = 0;
            end
            2: begin
                holdoff = 1000000; timeout = 24'hFFFFFF; confirm = 15;
                frac = 255; alpha = 1; critical = 65535;
            end
            3: begin
                holdoff = 500; timeout = 0; confirm = 3;
                frac = 128; alpha = 511; critical = 3000;
            end
            4: begin
                holdoff = 2000; timeout = 100000; confirm = 0;
                frac = 40; alpha = 0; critical = 1000;
            end
            5: begin
                holdoff = 1200; timeout = 50000; confirm = 8;
                frac = 200; alpha = 128; critical = 20000;
            end
            default: begin
                holdoff  = $urandom_range(20000, 0);
                timeout  = $urandom_range(200000, 0);
                confirm  = $urandom_range(15, 0);
                frac     = $urandom_range(255, 0);
                alpha    = $urandom_range(511, 0);
                critical = $urandom_range(65535, 0);
            end
        endcase
        write_reg(REG_HOLDOFF,   holdoff);
        write_reg(REG_TIMEOUT,   timeout);
        write_reg(REG_CONFIRM,   confirm);
        write_reg(REG_THRESHOLD, frac);
        write_reg(REG_ALPHA,     alpha);
        write_reg(REG_CRITICAL,  critical);
    endtask

    initial begin
        // Hold reset at first, then release it for the rest of the run.
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, run with the reset values of the registers.
        // Identical samples keep the range closed; the first low sample opens it.
        push_sample(1023, 32'd0);
        push_sample(1023, 32'd5);
        push_sample(0,    32'd10);
        // Five low samples past the hold-off confirm the first spark.
        push_sample(512,  32'd4000);
        push_sample(0,    32'd4010);
        push_sample(1,    32'd4020);
        push_sample(100,  32'd4030);
        push_sample(700,  32'd4040);
        // Inside the hold-off nothing moves; past it a high sample leaves the counter at zero.
        push_sample(1023, 32'd4050);
        push_sample(1023, 32'd8000);
        // A second spark five milliseconds later.
        for (int i = 0; i < 5; i++)
            push_sample(0, 32'd9000 + 32'(i * 10));
        // A long silence forces the average to zero.
        push_sample(1023, 32'd400000);
        // The two samples on either side of the low threshold, at the top of the time range.
        push_sample(819,  32'hFFFF_FFF0);
        push_sample(820,  32'hFFFF_FFFF);
        // A spark whose low burst straddles the timestamp wrap.
        push_sample(0, 32'hFFFF_FFFA);
        push_sample(0, 32'hFFFF_FFFC);
        push_sample(0, 32'hFFFF_FFFE);
        push_sample(0, 32'h0000_0001);
        push_sample(0, 32'h0000_0003);
        wait_drained();

        stim_clock = $urandom;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Rotate through the idling patterns: none, sender idle, receiver
            // stalling, and a light mix of both.
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            program_phase(ph);
            // One phase starts just below the wrap so spark periods cross it.
            if (ph == 4) stim_clock = 32'hFFFF_F000;

            // Mostly well-formed revolutions with random content, the rest noise.
            queued_count = 0;
            while (queued_count < PHASE_ITEMS) begin
                if ($urandom_range(99) < 80)
                    queue_revolution();
                else
                    queue_noise($urandom_range(8, 1));
            end
            wait_drained();
            // The sequencer is already back at rest once the result register empties.
            repeat (SETTLE_CYCLES) @(posedge aclk);
        end

        if (mismatches == 0 && reading_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
